### hw/rtl/ubns_pkg.sv
// Package: payload types, stage records, register map and constants of the UTF BOM / NUL sniffer.
`timescale 1ns / 1ps

package ubns_pkg;

   // counter width and the widths that follow from it
   localparam int CNT_BITS       = 32;
   localparam int POS_BITS       = CNT_BITS - 2;
   localparam int PERMILLE_BITS  = 10;
   localparam int PROD_BITS      = CNT_BITS + 11;
   localparam int PERMILLE_SCALE = 1000;

   // configuration port
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [PERMILLE_BITS-1:0] WIDE_ZERO_MIN_RESET  = PERMILLE_BITS'(100);
   localparam logic [PERMILLE_BITS-1:0] WIDE_DATA_MAX_RESET  = PERMILLE_BITS'(10);
   localparam logic [PERMILLE_BITS-1:0] UTF32_ZERO_MIN_RESET = PERMILLE_BITS'(900);

   typedef enum logic [1:0] {
      CSR_WIDE_ZERO_MIN  = 2'd0,
      CSR_WIDE_DATA_MAX  = 2'd1,
      CSR_UTF32_ZERO_MIN = 2'd2
   } csr_index_type;

   // BOM bytes
   localparam logic [7:0] BYTE_NUL = 8'h00;
   localparam logic [7:0] BYTE_FE  = 8'hFE;
   localparam logic [7:0] BYTE_FF  = 8'hFF;
   localparam logic [7:0] BYTE_EF  = 8'hEF;
   localparam logic [7:0] BYTE_BB  = 8'hBB;
   localparam logic [7:0] BYTE_BF  = 8'hBF;

   typedef enum logic [3:0] {
      VERDICT_NONE      = 4'd0,
      VERDICT_UTF8_BOM  = 4'd1,
      VERDICT_U16LE_BOM = 4'd2,
      VERDICT_U16BE_BOM = 4'd3,
      VERDICT_U32LE_BOM = 4'd4,
      VERDICT_U32BE_BOM = 4'd5,
      VERDICT_U16LE     = 4'd6,
      VERDICT_U16BE     = 4'd7,
      VERDICT_U32LE     = 4'd8,
      VERDICT_U32BE     = 4'd9,
      VERDICT_BINARY    = 4'd10
   } verdict_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      verdict_type verdict;
      logic [2:0]  bom_length;
      logic        nul_seen;
   } rsp_type;

   // file state captured on the last byte
   typedef struct packed {
      logic [3:0][CNT_BITS-1:0] nul_cnt;
      logic [CNT_BITS-1:0]      byte_cnt;
      logic [3:0][7:0]          head;
      logic                     any_nul;
   } snap_type;

   // scaled shares and thresholds, ready for comparison
   typedef struct packed {
      logic [3:0][PROD_BITS-1:0] nul_k;
      logic [PROD_BITS-1:0]      even_k;
      logic [PROD_BITS-1:0]      odd_k;
      logic [PROD_BITS-1:0]      t32;
      logic [PROD_BITS-1:0]      tmax;
      logic [PROD_BITS-1:0]      tzmin;
      logic                      pos_zero;
      logic                      u32_zero;
      logic                      zmin_zero;
      logic                      any_nul;
      logic                      quad;
      logic                      pair;
      logic                      ge2;
      logic                      ge3;
      logic                      ge4;
      logic [3:0][7:0]           head;
   } prod_type;

endpackage

### hw/rtl/utf_bom_and_nul_phase_sniffer_unit.sv
// Top level: UTF BOM and NUL-phase sniffer, byte stream in, one verdict per file out.
`timescale 1ns / 1ps

// Usage
//  - req channel: one file byte per transaction (req_payload.data_byte), with
//    req_payload.last_byte set on the final byte of the file.
//  - rsp channel: one transaction per file, issued for the final byte: verdict,
//    BOM length to skip and whether any NUL byte occurred.
//  - csr port (APB style, pready tied high): three 10-bit per-mille thresholds
//    at byte addresses 0, 4 and 8. Write only while no file is in flight.
//  - Throughput: one byte per clock while req_stall is low. Bytes are counted
//    in the running file state as they arrive; the next file may start on the
//    very next cycle. After the final byte is taken, the verdict passes through
//    the capture, product and result registers in that order.
//  - The three-deep verdict pipeline is held when the receiver stalls; bubbles
//    collapse, and req_stall rises only once every stage holds a verdict.
//  - Reset (synchronous, active high) clears the file state and pipeline and
//    loads the threshold defaults (100, 10, 900 per mille).
//  - Counters saturate at all ones; after each final byte the file state
//    returns to zero, thresholds are kept.

module utf_bom_and_nul_phase_sniffer_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ubns_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ubns_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ubns_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [ubns_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [ubns_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);

   localparam int CB = ubns_pkg::CNT_BITS;
   localparam int PB = ubns_pkg::PROD_BITS;
   localparam int TB = ubns_pkg::PERMILLE_BITS;
   localparam logic [CB-1:0] CNT_MAX = '1;

   // ---------------------------------------------------------------- csr
   logic [TB-1:0] zmin_ff;
   logic [TB-1:0] dmax_ff;
   logic [TB-1:0] u32_ff;
   logic          csr_wr;
   ubns_pkg::csr_index_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = ubns_pkg::csr_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         zmin_ff <= ubns_pkg::WIDE_ZERO_MIN_RESET;
         dmax_ff <= ubns_pkg::WIDE_DATA_MAX_RESET;
         u32_ff  <= ubns_pkg::UTF32_ZERO_MIN_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            ubns_pkg::CSR_WIDE_ZERO_MIN:  zmin_ff <= csr_pwdata[TB-1:0];
            ubns_pkg::CSR_WIDE_DATA_MAX:  dmax_ff <= csr_pwdata[TB-1:0];
            ubns_pkg::CSR_UTF32_ZERO_MIN: u32_ff  <= csr_pwdata[TB-1:0];
            default: ; // unmapped address, write dropped
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_idx)
         ubns_pkg::CSR_WIDE_ZERO_MIN:  csr_prdata = {{(ubns_pkg::CSR_DATA_BITS-TB){1'b0}}, zmin_ff};
         ubns_pkg::CSR_WIDE_DATA_MAX:  csr_prdata = {{(ubns_pkg::CSR_DATA_BITS-TB){1'b0}}, dmax_ff};
         ubns_pkg::CSR_UTF32_ZERO_MIN: csr_prdata = {{(ubns_pkg::CSR_DATA_BITS-TB){1'b0}}, u32_ff};
         default:                      csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------ pipeline flow control
   logic snap_vld_ff, prod_vld_ff, rsp_vld_ff;
   logic out_free, prod_free, snap_free;
   logic req_acc, last_acc;

   assign out_free  = ~rsp_vld_ff | ~rsp_stall;
   assign prod_free = ~prod_vld_ff | out_free;
   assign snap_free = ~snap_vld_ff | prod_free;
   assign req_stall = ~snap_free;
   assign req_acc   = req_valid & ~req_stall;
   assign last_acc  = req_acc & req_payload.last_byte;

   // --------------------------------------------------- running file state
   logic [CB-1:0]      cnt_ff, cnt_in;
   logic [3:0][7:0]    head_ff, head_in;
   logic [3:0][CB-1:0] nul_ff, nul_in;
   logic [1:0]         phase;
   logic               is_nul;

   assign phase  = cnt_ff[1:0];
   assign is_nul = (req_payload.data_byte == ubns_pkg::BYTE_NUL);

   always_comb begin
      cnt_in  = cnt_ff;
      head_in = head_ff;
      nul_in  = nul_ff;
      if (cnt_ff < CB'(4)) head_in[phase] = req_payload.data_byte;
      if (is_nul && nul_ff[phase] != CNT_MAX) nul_in[phase] = nul_ff[phase] + CB'(1);
      if (cnt_ff != CNT_MAX) cnt_in = cnt_ff + CB'(1);
   end

   always_ff @(posedge clock) begin
      if (reset || last_acc) begin
         cnt_ff  <= '0;
         head_ff <= '0;
         nul_ff  <= '0;
      end else if (req_acc) begin
         cnt_ff  <= cnt_in;
         head_ff <= head_in;
         nul_ff  <= nul_in;
      end
   end

   // ------------------------------------------------ stage 1: capture
   ubns_pkg::snap_type snap_ff;

   always_ff @(posedge clock) begin
      if (reset) snap_vld_ff <= 1'b0;
      else if (snap_free) snap_vld_ff <= last_acc;
   end

   always_ff @(posedge clock) begin
      if (last_acc) begin
         snap_ff.nul_cnt  <= nul_in;
         snap_ff.byte_cnt <= cnt_in;
         snap_ff.head     <= head_in;
         snap_ff.any_nul  <= (nul_in[0] | nul_in[1] | nul_in[2] | nul_in[3]) != '0;
      end
   end

   // ------------------------------------------------ stage 2: products
   // share >= thr/1000  <=>  count*1000 >= thr*positions (times 2 for a pair)
   ubns_pkg::prod_type prod_ff, prod_in;
   logic [ubns_pkg::POS_BITS-1:0] pos;

   assign pos = snap_ff.byte_cnt[CB-1:2];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         prod_in.nul_k[k] = PB'(snap_ff.nul_cnt[k]) * PB'(ubns_pkg::PERMILLE_SCALE);
      end
      prod_in.even_k    = (PB'(snap_ff.nul_cnt[0]) + PB'(snap_ff.nul_cnt[2]))
                          * PB'(ubns_pkg::PERMILLE_SCALE);
      prod_in.odd_k     = (PB'(snap_ff.nul_cnt[1]) + PB'(snap_ff.nul_cnt[3]))
                          * PB'(ubns_pkg::PERMILLE_SCALE);
      prod_in.t32       = PB'(u32_ff)  * PB'(pos);
      prod_in.tmax      = PB'(dmax_ff) * PB'(pos);
      prod_in.tzmin     = PB'(zmin_ff) * PB'(pos);
      prod_in.pos_zero  = (pos == '0);
      prod_in.u32_zero  = (u32_ff == '0);
      prod_in.zmin_zero = (zmin_ff == '0);
      prod_in.any_nul   = snap_ff.any_nul;
      prod_in.quad      = (snap_ff.byte_cnt[1:0] == 2'b00);
      prod_in.pair      = ~snap_ff.byte_cnt[0];
      prod_in.ge2       = (snap_ff.byte_cnt >= CB'(2));
      prod_in.ge3       = (snap_ff.byte_cnt >= CB'(3));
      prod_in.ge4       = (snap_ff.byte_cnt >= CB'(4));
      prod_in.head      = snap_ff.head;
   end

   always_ff @(posedge clock) begin
      if (reset) prod_vld_ff <= 1'b0;
      else if (prod_free) prod_vld_ff <= snap_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (prod_free && snap_vld_ff) prod_ff <= prod_in;
   end

   // ------------------------------------------------ stage 3: verdict
   ubns_pkg::rsp_type rsp_ff, rsp_in;
   logic [3:0][7:0]   h;
   logic [PB-1:0]     tmax2, tzmin2;
   logic bom32le, bom32be, bom8, bom16le, bom16be;
   logic p2_hi, p3_hi, p0_hi, p1_hi, p0_lo, p3_lo;
   logic odd_hi, even_hi, odd_lo, even_lo;

   assign h      = prod_ff.head;
   assign tmax2  = {prod_ff.tmax[PB-2:0], 1'b0};
   assign tzmin2 = {prod_ff.tzmin[PB-2:0], 1'b0};

   assign bom32le = prod_ff.ge4 && h[0] == ubns_pkg::BYTE_FF && h[1] == ubns_pkg::BYTE_FE
                    && h[2] == ubns_pkg::BYTE_NUL && h[3] == ubns_pkg::BYTE_NUL;
   assign bom32be = prod_ff.ge4 && h[0] == ubns_pkg::BYTE_NUL && h[1] == ubns_pkg::BYTE_NUL
                    && h[2] == ubns_pkg::BYTE_FE && h[3] == ubns_pkg::BYTE_FF;
   assign bom8    = prod_ff.ge3 && h[0] == ubns_pkg::BYTE_EF && h[1] == ubns_pkg::BYTE_BB
                    && h[2] == ubns_pkg::BYTE_BF;
   assign bom16le = prod_ff.ge2 && h[0] == ubns_pkg::BYTE_FF && h[1] == ubns_pkg::BYTE_FE;
   assign bom16be = prod_ff.ge2 && h[0] == ubns_pkg::BYTE_FE && h[1] == ubns_pkg::BYTE_FF;

   // zero positions: a share is zero, so ">=" needs a zero threshold and "<=" always holds
   assign p0_hi   = prod_ff.pos_zero ? prod_ff.u32_zero  : prod_ff.nul_k[0] >= prod_ff.t32;
   assign p1_hi   = prod_ff.pos_zero ? prod_ff.u32_zero  : prod_ff.nul_k[1] >= prod_ff.t32;
   assign p2_hi   = prod_ff.pos_zero ? prod_ff.u32_zero  : prod_ff.nul_k[2] >= prod_ff.t32;
   assign p3_hi   = prod_ff.pos_zero ? prod_ff.u32_zero  : prod_ff.nul_k[3] >= prod_ff.t32;
   assign p0_lo   = prod_ff.pos_zero | (prod_ff.nul_k[0] <= prod_ff.tmax);
   assign p3_lo   = prod_ff.pos_zero | (prod_ff.nul_k[3] <= prod_ff.tmax);
   assign odd_hi  = prod_ff.pos_zero ? prod_ff.zmin_zero : prod_ff.odd_k >= tzmin2;
   assign even_hi = prod_ff.pos_zero ? prod_ff.zmin_zero : prod_ff.even_k >= tzmin2;
   assign odd_lo  = prod_ff.pos_zero | (prod_ff.odd_k <= tmax2);
   assign even_lo = prod_ff.pos_zero | (prod_ff.even_k <= tmax2);

   always_comb begin
      rsp_in.verdict    = ubns_pkg::VERDICT_NONE;
      rsp_in.bom_length = 3'd0;
      rsp_in.nul_seen   = prod_ff.any_nul;
      priority if (bom32le) begin
         rsp_in.verdict    = ubns_pkg::VERDICT_U32LE_BOM;
         rsp_in.bom_length = 3'd4;
      end else if (bom32be) begin
         rsp_in.verdict    = ubns_pkg::VERDICT_U32BE_BOM;
         rsp_in.bom_length = 3'd4;
      end else if (bom8) begin
         rsp_in.verdict    = ubns_pkg::VERDICT_UTF8_BOM;
         rsp_in.bom_length = 3'd3;
      end else if (bom16le) begin
         rsp_in.verdict    = ubns_pkg::VERDICT_U16LE_BOM;
         rsp_in.bom_length = 3'd2;
      end else if (bom16be) begin
         rsp_in.verdict    = ubns_pkg::VERDICT_U16BE_BOM;
         rsp_in.bom_length = 3'd2;
      end else if (prod_ff.any_nul) begin
         priority if (prod_ff.quad && p2_hi && p3_hi && p0_lo) begin
            rsp_in.verdict = ubns_pkg::VERDICT_U32LE;
         end else if (prod_ff.quad && p0_hi && p1_hi && p3_lo) begin
            rsp_in.verdict = ubns_pkg::VERDICT_U32BE;
         end else if (prod_ff.pair && odd_hi && even_lo) begin
            rsp_in.verdict = ubns_pkg::VERDICT_U16LE;
         end else if (prod_ff.pair && even_hi && odd_lo) begin
            rsp_in.verdict = ubns_pkg::VERDICT_U16BE;
         end else begin
            rsp_in.verdict = ubns_pkg::VERDICT_BINARY;
         end
      end else begin
         rsp_in.verdict = ubns_pkg::VERDICT_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_vld_ff <= 1'b0;
      else if (out_free) rsp_vld_ff <= prod_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (out_free && prod_vld_ff) rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_vld_ff;
   assign rsp_payload = rsp_ff;

endmodule

### bench/tb.sv
// Testbench for the UTF BOM / NUL-phase sniffer: directed files, random files and a scoreboard.
`timescale 1ns / 1ps

module tb;
   import ubns_pkg::*;

   localparam int HALF_PERIOD      = 5;
   localparam int RESET_CYCLES     = 12;
   localparam int SETTLE_CYCLES    = 8;     // three-stage verdict pipeline, plus margin
   localparam int HOLD_CYCLES      = 80;    // long receiver hold-off, fills the pipeline
   localparam int HOLD_FILES       = 24;    // one-byte files offered during the hold-off
   localparam int WATCHDOG_LIMIT   = 5000;  // cycles with no transaction anywhere
   localparam int RANDOM_BYTES     = 1300;
   localparam int PHASE_COUNT      = 6;
   localparam int PRESSURE_PHASE   = 2;
   localparam int SHOWN_MISMATCHES = 10;
   localparam int SWAP_IDLE_AT     = 450;   // bytes sent before the idling roles swap
   localparam int NO_IDLE_AT       = 900;   // bytes sent before idling stops
   localparam int DIRECTED_ROWS    = 24;

   localparam longint unsigned SCALE = 1000;
   localparam logic [CNT_BITS-1:0] COUNT_TOP = '1;
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;  // no register behind this index

   // BOM patterns, first byte in the top byte lane
   localparam logic [31:0] BOM_U32LE = {BYTE_FF, BYTE_FE, BYTE_NUL, BYTE_NUL};
   localparam logic [31:0] BOM_U32BE = {BYTE_NUL, BYTE_NUL, BYTE_FE, BYTE_FF};
   localparam logic [31:0] BOM_UTF8  = {BYTE_EF, BYTE_BB, BYTE_BF, BYTE_NUL};
   localparam logic [31:0] BOM_U16LE = {BYTE_FF, BYTE_FE, BYTE_NUL, BYTE_NUL};
   localparam logic [31:0] BOM_U16BE = {BYTE_FE, BYTE_FF, BYTE_NUL, BYTE_NUL};
   localparam logic [31:0] BOM_BYTES [5] = '{BOM_U32LE, BOM_U32BE, BOM_UTF8, BOM_U16LE,
                                             BOM_U16BE};
   localparam int BOM_LEN [5] = '{4, 4, 3, 2, 2};
   localparam int NOISE_PCT [6] = '{0, 0, 1, 3, 10, 40};

   localparam rsp_type NO_VERDICT = '{VERDICT_NONE, 3'd0, 1'b0};

   typedef enum int {
      FILE_TEXT,
      FILE_U16LE,
      FILE_U16BE,
      FILE_U32LE,
      FILE_U32BE,
      FILE_NOISE
   } file_kind_t;

   // one row per byte; 'typed' rows carry a verdict that is obvious by inspection
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       typed;
      rsp_type    fixed;
   } script_row_t;

   localparam script_row_t DIRECTED [DIRECTED_ROWS] = '{
      // plain two-byte file straight after reset: no BOM, no NUL
      '{8'h41, 1'b0, 1'b0, NO_VERDICT},
      '{8'h41, 1'b1, 1'b1, NO_VERDICT},
      // UTF-32LE BOM, which also starts with the UTF-16LE BOM: the longer one wins
      '{8'hFF, 1'b0, 1'b0, NO_VERDICT},
      '{8'hFE, 1'b0, 1'b0, NO_VERDICT},
      '{8'h00, 1'b0, 1'b0, NO_VERDICT},
      '{8'h00, 1'b1, 1'b1, '{VERDICT_U32LE_BOM, 3'd4, 1'b1}},
      // UTF-32BE BOM
      '{8'h00, 1'b0, 1'b0, NO_VERDICT},
      '{8'h00, 1'b0, 1'b0, NO_VERDICT},
      '{8'hFE, 1'b0, 1'b0, NO_VERDICT},
      '{8'hFF, 1'b1, 1'b1, '{VERDICT_U32BE_BOM, 3'd4, 1'b1}},
      // UTF-8 BOM
      '{8'hEF, 1'b0, 1'b0, NO_VERDICT},
      '{8'hBB, 1'b0, 1'b0, NO_VERDICT},
      '{8'hBF, 1'b1, 1'b1, '{VERDICT_UTF8_BOM, 3'd3, 1'b0}},
      // UTF-16 BOMs on their own
      '{8'hFF, 1'b0, 1'b0, NO_VERDICT},
      '{8'hFE, 1'b1, 1'b1, '{VERDICT_U16LE_BOM, 3'd2, 1'b0}},
      '{8'hFE, 1'b0, 1'b0, NO_VERDICT},
      '{8'hFF, 1'b1, 1'b1, '{VERDICT_U16BE_BOM, 3'd2, 1'b0}},
      // lone NUL: odd length, no position, so binary
      '{8'h00, 1'b1, 1'b1, '{VERDICT_BINARY, 3'd0, 1'b1}},
      // truncated UTF-8 BOM must not match
      '{8'hEF, 1'b0, 1'b0, NO_VERDICT},
      '{8'hBB, 1'b1, 1'b1, NO_VERDICT},
      // two-byte files with a NUL: zero positions, left to the predictor
      '{8'h41, 1'b0, 1'b0, NO_VERDICT},
      '{8'h00, 1'b1, 1'b0, NO_VERDICT},
      '{8'h00, 1'b0, 1'b0, NO_VERDICT},
      '{8'h41, 1'b1, 1'b0, NO_VERDICT}
   };

   // DUT ports; every input known from time zero
   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_stall;
   req_type                  req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_stall   = 1'b0;
   rsp_type                  rsp_payload;
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   // predictor copy of the file state and thresholds
   logic [CNT_BITS-1:0]            file_len;
   logic [3:0][7:0]                file_head;
   logic [3:0][CNT_BITS-1:0]       nul_tally;
   logic [PERMILLE_BITS-1:0]       zero_min_pm;
   logic [PERMILLE_BITS-1:0]       data_max_pm;
   logic [PERMILLE_BITS-1:0]       u32_min_pm;

   rsp_type verdict_q [$];          // verdicts still owed by the DUT
   int      mismatch_count = 0;
   int      quiet_cycles   = 0;
   int      bytes_sent     = 0;
   int      req_idle_pct   = 31;
   int      rsp_idle_pct   = 58;
   bit      hold_off_req   = 1'b0;

   utf_bom_and_nul_phase_sniffer_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic void clear_file();
      file_len  = '0;
      file_head = '0;
      nul_tally = '0;
   endfunction

   // share = sum / (den * pos) compared exactly against thr / 1000; no positions = zero share
   function automatic bit share_at_least(longint unsigned sum, longint unsigned den,
                                         longint unsigned thr, longint unsigned pos);
      if (pos == 0) return thr == 0;
      return sum * SCALE >= thr * den * pos;
   endfunction

   function automatic bit share_at_most(longint unsigned sum, longint unsigned den,
                                        longint unsigned thr, longint unsigned pos);
      if (pos == 0) return 1'b1;
      return sum * SCALE <= thr * den * pos;
   endfunction

   // a BOM only counts once the file is at least as long as the BOM
   function automatic bit head_matches(logic [31:0] pat, int len);
      for (int i = 0; i < len; i++) begin
         if (file_head[i] != pat[31-8*i -: 8]) return 1'b0;
      end
      return file_len >= CNT_BITS'(len);
   endfunction

   function automatic rsp_type predict_verdict();
      rsp_type         r;
      longint unsigned c [4];
      longint unsigned pos;
      longint unsigned even_sum;
      longint unsigned odd_sum;
      logic            any_nul;
      for (int p = 0; p < 4; p++) c[p] = nul_tally[p];
      pos      = file_len / 4;
      even_sum = c[0] + c[2];
      odd_sum  = c[1] + c[3];
      any_nul  = |nul_tally;
      r        = NO_VERDICT;
      r.nul_seen = any_nul;
      // BOMs first, longest and most specific first
      if (head_matches(BOM_U32LE, 4)) begin
         r.verdict = VERDICT_U32LE_BOM; r.bom_length = 3'd4;
      end else if (head_matches(BOM_U32BE, 4)) begin
         r.verdict = VERDICT_U32BE_BOM; r.bom_length = 3'd4;
      end else if (head_matches(BOM_UTF8, 3)) begin
         r.verdict = VERDICT_UTF8_BOM; r.bom_length = 3'd3;
      end else if (head_matches(BOM_U16LE, 2)) begin
         r.verdict = VERDICT_U16LE_BOM; r.bom_length = 3'd2;
      end else if (head_matches(BOM_U16BE, 2)) begin
         r.verdict = VERDICT_U16BE_BOM; r.bom_length = 3'd2;
      end else if (any_nul) begin
         // NUL phases: UTF-32 needs a whole number of quads, UTF-16 of pairs
         r.verdict = VERDICT_BINARY;
         if (file_len[1:0] == 2'd0 && share_at_least(c[2], 1, u32_min_pm, pos) &&
             share_at_least(c[3], 1, u32_min_pm, pos) &&
             share_at_most(c[0], 1, data_max_pm, pos)) begin
            r.verdict = VERDICT_U32LE;
         end else if (file_len[1:0] == 2'd0 && share_at_least(c[0], 1, u32_min_pm, pos) &&
                      share_at_least(c[1], 1, u32_min_pm, pos) &&
                      share_at_most(c[3], 1, data_max_pm, pos)) begin
            r.verdict = VERDICT_U32BE;
         end else if (!file_len[0]) begin
            if (share_at_least(odd_sum, 2, zero_min_pm, pos) &&
                share_at_most(even_sum, 2, data_max_pm, pos)) begin
               r.verdict = VERDICT_U16LE;
            end else if (share_at_least(even_sum, 2, zero_min_pm, pos) &&
                         share_at_most(odd_sum, 2, data_max_pm, pos)) begin
               r.verdict = VERDICT_U16BE;
            end
         end
      end
      return r;
   endfunction

   // fold one accepted byte into the file state; the last byte owes a verdict
   function automatic void count_byte(logic [7:0] b, logic last, logic typed, rsp_type fixed);
      logic [1:0] ph;
      rsp_type    predicted;
      ph = file_len[1:0];
      if (file_len < CNT_BITS'(4)) file_head[ph] = b;
      if (b == BYTE_NUL && nul_tally[ph] != COUNT_TOP) nul_tally[ph]++;
      if (file_len != COUNT_TOP) file_len++;
      if (last) begin
         predicted = predict_verdict();
         verdict_q.insert(verdict_q.size(), typed ? fixed : predicted);
         clear_file();
      end
   endfunction

   // ---------------------------------------------------------------- drivers

   // offer one byte, wait for the transaction, then predict
   task automatic put_byte(input logic [7:0] b, input logic last, input logic typed,
                           input rsp_type fixed);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{data_byte: b, last_byte: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      count_byte(b, last, typed, fixed);
      bytes_sent++;
      // receiver-heavy idling first, then sender-heavy, then flat out
      if (bytes_sent >= NO_IDLE_AT) begin
         req_idle_pct = 0;
         rsp_idle_pct = 0;
      end else if (bytes_sent >= SWAP_IDLE_AT) begin
         req_idle_pct = 58;
         rsp_idle_pct = 31;
      end
   endtask

   // drop valid and wait for every owed verdict, plus the pipeline depth
   task automatic settle();
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write: setup, access, taken at the access edge once pready is high
   task automatic write_threshold(input logic [1:0] idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      case (idx)
         CSR_WIDE_ZERO_MIN:  zero_min_pm = value[PERMILLE_BITS-1:0];
         CSR_WIDE_DATA_MAX:  data_max_pm = value[PERMILLE_BITS-1:0];
         CSR_UTF32_ZERO_MIN: u32_min_pm  = value[PERMILLE_BITS-1:0];
         default: ;  // unmapped: nothing changes
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // one random file: optional (possibly cut) BOM, then text shaped like one encoding
   task automatic send_file();
      logic [7:0] body [$];
      file_kind_t kind;
      int         len;
      int         noise;
      int         unit;
      int         k;
      int         blen;
      int         i;
      logic       zero;
      logic [7:0] b;
      kind  = file_kind_t'($urandom_range(0, 5));
      noise = NOISE_PCT[$urandom_range(0, 5)];
      len   = ($urandom_range(0, 15) == 0) ? $urandom_range(49, 300) : $urandom_range(1, 48);
      // wide encodings mostly come in whole code units
      if (kind inside {FILE_U16LE, FILE_U16BE, FILE_U32LE, FILE_U32BE} &&
          $urandom_range(0, 4) != 0) begin
         unit = (kind inside {FILE_U32LE, FILE_U32BE}) ? 4 : 2;
         len  = ((len + unit - 1) / unit) * unit;
      end
      if ($urandom_range(0, 3) == 0) begin
         k    = $urandom_range(0, 4);
         blen = ($urandom_range(0, 3) == 0) ? $urandom_range(1, BOM_LEN[k]) : BOM_LEN[k];
         for (int j = 0; j < blen; j++) body.insert(body.size(), BOM_BYTES[k][31-8*j -: 8]);
      end
      while (body.size() < len) begin
         i = body.size();
         case (kind)
            FILE_U16LE: zero = i[0];
            FILE_U16BE: zero = !i[0];
            FILE_U32LE: zero = (i[1:0] >= 2) || (i[1:0] == 1 && $urandom_range(0, 3) != 0);
            FILE_U32BE: zero = (i[1:0] <= 1) || (i[1:0] == 2 && $urandom_range(0, 3) != 0);
            FILE_NOISE: zero = ($urandom_range(0, 3) == 0);
            default:    zero = 1'b0;
         endcase
         b = zero ? BYTE_NUL : 8'($urandom_range(1, 255));
         if ($urandom_range(0, 99) < noise) b = 8'($urandom_range(0, 255));
         body.insert(body.size(), b);
      end
      for (int j = 0; j < body.size(); j++) begin
         put_byte(body[j], j == body.size() - 1, 1'b0, NO_VERDICT);
      end
   endtask

   // ---------------------------------------------------------------- receiver

   // random stall per mode; on request one long hold-off counted here
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
      end
   end

   // ---------------------------------------------------------------- scoreboard and watchdog

   task automatic report_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatch_count++;
      if (mismatch_count <= SHOWN_MISMATCHES) begin
         $display("mismatch %0d (%s) at %0t: expected %0d/%0d/%0d got %0d/%0d/%0d",
                  mismatch_count, what, $realtime, want.verdict, want.bom_length,
                  want.nul_seen, got.verdict, got.bom_length, got.nul_seen);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) begin
               report_mismatch("unexpected transaction", NO_VERDICT, rsp_payload);
            end else begin
               want = verdict_q.pop_front();
               if (rsp_payload.verdict !== want.verdict ||
                   rsp_payload.bom_length !== want.bom_length ||
                   rsp_payload.nul_seen !== want.nul_seen) begin
                  report_mismatch("field", want, rsp_payload);
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_psel && csr_penable)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d verdicts owed",
                     quiet_cycles, verdict_q.size());
            $display("FAIL");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin
      logic [CSR_DATA_BITS-1:0] zmin;
      logic [CSR_DATA_BITS-1:0] dmax;
      logic [CSR_DATA_BITS-1:0] u32;
      zero_min_pm = WIDE_ZERO_MIN_RESET;
      data_max_pm = WIDE_DATA_MAX_RESET;
      u32_min_pm  = UTF32_ZERO_MIN_RESET;
      clear_file();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed files at the reset thresholds
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         put_byte(DIRECTED[r].data_byte, DIRECTED[r].last_byte, DIRECTED[r].typed,
                  DIRECTED[r].fixed);
      end

      // random files, one threshold setting per phase; writes only while idle
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         settle();
         case (ph)
            0: begin  // all zero: any share passes a minimum, only a zero share passes a maximum
               zmin = '0; dmax = '0; u32 = '0;
            end
            1: begin  // all at full scale
               zmin = 32'd1000; dmax = 32'd1000; u32 = 32'd1000;
            end
            2: begin  // junk in the upper bits, which are dropped: zmin and dmax keep 1023, u32 keeps 0
               zmin = '1; dmax = 32'hABCD_E3FF; u32 = 32'h1234_5400;
            end
            3, 4: begin
               zmin = 32'($urandom_range(0, 1000));
               dmax = 32'($urandom_range(0, 200));
               u32  = 32'($urandom_range(500, 1000));
            end
            default: begin  // back to the power-on values
               zmin = 32'(WIDE_ZERO_MIN_RESET);
               dmax = 32'(WIDE_DATA_MAX_RESET);
               u32  = 32'(UTF32_ZERO_MIN_RESET);
            end
         endcase
         write_threshold(CSR_WIDE_ZERO_MIN, zmin);
         write_threshold(CSR_WIDE_DATA_MAX, dmax);
         write_threshold(CSR_UTF32_ZERO_MIN, u32);
         if (ph == PRESSURE_PHASE) write_threshold(CSR_UNMAPPED, $urandom());

         while (bytes_sent < DIRECTED_ROWS + (ph + 1) * RANDOM_BYTES / PHASE_COUNT) begin
            send_file();
         end

         // back-pressure: receiver holds off while one-byte files keep coming
         if (ph == PRESSURE_PHASE) begin
            hold_off_req = 1'b1;
            repeat (HOLD_FILES) put_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, NO_VERDICT);
         end
      end

      settle();
      if (mismatch_count == 0 && verdict_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/ubns_pkg.sv
hw/rtl/utf_bom_and_nul_phase_sniffer_unit.sv
bench/tb.sv
